>>> sv/fpc_pkg.sv
// Shared types and constants for the frustum point containment block.
// No dependencies.
`timescale 1ns / 1ps

package fpc_pkg;

  localparam int ELEM_W = 32;
  localparam int ROW_N  = 4;
  localparam int PROD_W = 2 * ELEM_W;
  // row dot product: three products plus the w term, fits for up to 32 fraction bits
  localparam int DOT_W  = PROD_W + 2;
  localparam int PLANE_W = DOT_W + 1;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_e;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [ROW_N-1:0]        row_t;
  typedef row_t  [ROW_N-1:0]        matrix_t;
  typedef elem_t [2:0]              point_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef dot_t  [ROW_N-1:0]        dots_t;

  typedef struct packed {
    logic       adv;
    logic       load_we;
    logic [1:0] load_row;
  } pipe_ctrl_t;

endpackage

>>> sv/fpc_matrix_store.sv
// 4x4 matrix register file, one row written per load beat, reset to zero.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_matrix_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpc_pkg::pipe_ctrl_t ctrl_i,
  input  fpc_pkg::row_t      wdata_i,
  output fpc_pkg::matrix_t   matrix_o
);
  import fpc_pkg::*;

  matrix_t mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
    end else if (ctrl_i.adv && ctrl_i.load_we) begin
      mat_q[ctrl_i.load_row] <= wdata_i;
    end
  end

  assign matrix_o = mat_q;

endmodule

>>> sv/fpc_row_dot.sv
// Two-stage row dot product row . (x, y, z, 1) in fixed point.
// Stage one registers the three products and the w term, stage two the sum.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_row_dot #(
  parameter int FracBits = 16
) (
  input  logic            clk_i,
  input  logic            adv_i,
  input  fpc_pkg::row_t   row_i,
  input  fpc_pkg::point_t point_i,
  output fpc_pkg::dot_t   dot_o
);
  import fpc_pkg::*;

  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] prod_q [3];
  dot_t w_d, w_q, dot_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      prod_d[j] = PROD_W'(row_i[j]) * PROD_W'(point_i[j]);
    end
    w_d = {{(DOT_W-ELEM_W-FracBits){row_i[3][ELEM_W-1]}}, row_i[3], {FracBits{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[j] <= prod_d[j];
      end
      w_q   <= w_d;
      dot_q <= DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]) + w_q;
    end
  end

  assign dot_o = dot_q;

endmodule

>>> sv/fpc_plane_test.sv
// Six plane signs from the four row dot products: row3 +/- row0, row1, row2.
// Depends on fpc_pkg.
`timescale 1ns / 1ps

module fpc_plane_test (
  input  fpc_pkg::dots_t dots_i,
  output logic           inside_o
);
  import fpc_pkg::*;

  logic signed [PLANE_W-1:0] plus_v  [3];
  logic signed [PLANE_W-1:0] minus_v [3];
  logic [5:0] pos;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      plus_v[r]  = PLANE_W'(dots_i[3]) + PLANE_W'(dots_i[r]);
      minus_v[r] = PLANE_W'(dots_i[3]) - PLANE_W'(dots_i[r]);
      pos[2*r]   = !plus_v[r][PLANE_W-1]  && (plus_v[r]  != '0);
      pos[2*r+1] = !minus_v[r][PLANE_W-1] && (minus_v[r] != '0);
    end
  end

  assign inside_o = &pos;

endmodule

>>> sv/frustum_point_containment.sv
// Frustum point containment: an accepted test beat passes the input register, the
// product stage, the sum stage and the output register before its result beat is
// valid; one beat accepted per cycle (fully pipelined) unless the result side stalls.
// A load beat writes its matrix row from the input register and gives no result.
// Async active-low reset clears the matrix to zero and empties the pipeline.
// Any stall on the result side holds every stage.
// Depends on fpc_pkg, fpc_matrix_store, fpc_row_dot, fpc_plane_test.
`timescale 1ns / 1ps

module frustum_point_containment #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [1:0]          row_index_i,
  input  logic signed [31:0]  elem0_i,
  input  logic signed [31:0]  elem1_i,
  input  logic signed [31:0]  elem2_i,
  input  logic signed [31:0]  elem3_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                inside_res_o
);
  import fpc_pkg::*;

  logic       adv;
  logic       s0_valid_q, s1_valid_q, s2_valid_q, out_valid_q;
  kind_e      s0_kind_q;
  logic [1:0] s0_row_q;
  row_t       s0_elems_q;
  point_t     s0_pt_q;
  logic       inside_q;
  pipe_ctrl_t ctrl;
  matrix_t    matrix;
  dots_t      dots;
  logic       inside_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q && (s0_kind_q == KIND_TEST);
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s0_kind_q  <= kind_e'(kind_i);
      s0_row_q   <= row_index_i;
      s0_elems_q <= {elem3_i, elem2_i, elem1_i, elem0_i};
      s0_pt_q    <= {point_z_i, point_y_i, point_x_i};
    end
    if (adv && s2_valid_q) begin
      inside_q <= inside_d;
    end
  end

  assign ctrl.adv      = adv;
  assign ctrl.load_we  = s0_valid_q && (s0_kind_q == KIND_LOAD);
  assign ctrl.load_row = s0_row_q;

  fpc_matrix_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .wdata_i  (s0_elems_q),
    .matrix_o (matrix)
  );

  for (genvar r = 0; r < ROW_N; r++) begin : g_row
    fpc_row_dot #(
      .FracBits (FRAC_BITS)
    ) u_dot (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .row_i   (matrix[r]),
      .point_i (s0_pt_q),
      .dot_o   (dots[r])
    );
  end

  fpc_plane_test u_planes (
    .dots_i   (dots),
    .inside_o (inside_d)
  );

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

`ifndef SYNTH
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_valid_q && (s0_kind_q == KIND_LOAD)) |=> !s1_valid_q)
    else $error("load beat entered the result pipeline");
  a_test_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s0_valid_q && (s0_kind_q == KIND_TEST)) |=> s1_valid_q)
    else $error("test beat dropped");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s1_valid_q) && $stable(s2_valid_q) && $stable(s0_valid_q)))
    else $error("pipeline moved during stall");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s2_valid_q))
    else $error("result without a test in flight");
`endif

endmodule
